[hw/rtl/b64c_pkg.sv]
// ----------------------------------------------------------------------------
// b64c_pkg
// shared types, codes and lookup functions for the base64 codec
// ----------------------------------------------------------------------------
package b64c_pkg;

    localparam logic [7:0] PAD_CHAR  = 8'h3D;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic       MODE_ENC  = 1'b0;

    typedef struct packed {
        logic       last;
        logic [1:0] kind;
        logic [7:0] data;
    } t_res;

    typedef struct packed {
        logic [2:0]     cnt;
        t_res [3:0]     res;
    } t_pkt;

    function automatic logic [7:0] char_of(input logic [5:0] sx);
        logic [7:0] c;
        c = {2'b00, sx};
        if (sx < 6'd26) begin
            c = 8'h41 + c;
        end else if (sx < 6'd52) begin
            c = 8'h61 + c - 8'd26;
        end else if (sx < 6'd62) begin
            c = 8'h30 + c - 8'd52;
        end else if (sx == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // bit 6 set when the character is not in the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] s;
        s = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s = 7'd62;
        end else if (c == 8'h2F) begin
            s = 7'd63;
        end
        return s;
    endfunction

    function automatic t_res mk_res(input logic [7:0] d, input logic [1:0] k,
                                    input logic l);
        t_res r;
        r.data = d;
        r.kind = k;
        r.last = l;
        return r;
    endfunction

    function automatic t_pkt decode_tail(input logic [1:0] i, input logic [5:0] s0,
                                         input logic [5:0] s1, input logic [5:0] s2);
        t_pkt p;
        p = '0;
        if (i <= 2'd1) begin
            p.cnt    = 3'd1;
            p.res[0] = mk_res(8'h00, KIND_END, 1'b1);
        end else if (i == 2'd2) begin
            p.cnt    = 3'd1;
            p.res[0] = mk_res({s0, s1[5:4]}, KIND_DATA, 1'b1);
        end else begin
            p.cnt    = 3'd2;
            p.res[0] = mk_res({s0, s1[5:4]}, KIND_DATA, 1'b0);
            p.res[1] = mk_res({s1[3:0], s2[5:2]}, KIND_DATA, 1'b1);
        end
        return p;
    endfunction

endpackage

[hw/rtl/b64c_front.sv]
// ----------------------------------------------------------------------------
// b64c_front
// accepts input beats, gathers groups and builds result packets
// ----------------------------------------------------------------------------
module b64c_front
    import b64c_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_acc,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output logic       o_push,
    output t_pkt       o_pkt
);

    logic       r_mode, n_mode;
    logic [1:0] r_cnt, n_cnt;
    logic       r_halted, n_halted;
    logic       r_errored, n_errored;
    logic [7:0] r_store [3];
    logic [7:0] n_store [3];

    logic [1:0] cnt_e;
    logic [7:0] b0, b1, b2;
    logic [5:0] ex [4];
    logic [2:0] nchar;
    logic [6:0] sxv;
    logic [5:0] sx;
    t_pkt       pkt;

    always_comb begin
        n_mode    = r_mode;
        n_cnt     = r_cnt;
        n_halted  = r_halted;
        n_errored = r_errored;
        n_store   = r_store;
        pkt       = '0;
        cnt_e     = (r_cnt == 2'd3) ? 2'd0 : r_cnt;
        b0        = 8'h00;
        b1        = 8'h00;
        b2        = 8'h00;
        ex[0]     = '0;
        ex[1]     = '0;
        ex[2]     = '0;
        ex[3]     = '0;
        nchar     = 3'd4;
        sxv       = sextet_of(i_data);
        sx        = sxv[5:0];
        if (i_cfg_wr_en) begin
            n_mode    = i_cfg_wr_data;
            n_cnt     = 2'd0;
            n_halted  = 1'b0;
            n_errored = 1'b0;
        end else if (i_acc) begin
            if (r_mode == MODE_ENC) begin
                n_store[cnt_e] = i_data;
                if (cnt_e == 2'd2 || i_last) begin
                    b0    = n_store[0];
                    b1    = (cnt_e >= 2'd1) ? n_store[1] : 8'h00;
                    b2    = (cnt_e == 2'd2) ? n_store[2] : 8'h00;
                    ex[0] = b0[7:2];
                    ex[1] = {b0[1:0], b1[7:4]};
                    ex[2] = {b1[3:0], b2[7:6]};
                    ex[3] = b2[5:0];
                    nchar = (cnt_e == 2'd2) ? 3'd4 : 3'({1'b0, cnt_e} + 3'd2);
                    pkt.cnt = 3'd4;
                    for (int k = 0; k < 4; k++) begin
                        pkt.res[k] = mk_res((3'(k) < nchar) ? char_of(ex[k]) : PAD_CHAR,
                                            KIND_DATA, (k == 3) ? i_last : 1'b0);
                    end
                    n_cnt = 2'd0;
                end else begin
                    n_cnt = cnt_e + 2'd1;
                end
            end else if (r_errored) begin
                if (i_last) begin
                    n_cnt     = 2'd0;
                    n_halted  = 1'b0;
                    n_errored = 1'b0;
                end
            end else if (r_halted || i_data == PAD_CHAR) begin
                n_halted = 1'b1;
                if (i_last) begin
                    pkt      = decode_tail(r_cnt, r_store[0][5:0], r_store[1][5:0],
                                           r_store[2][5:0]);
                    n_cnt    = 2'd0;
                    n_halted = 1'b0;
                end
            end else if (sxv[6]) begin
                pkt.cnt    = 3'd1;
                pkt.res[0] = mk_res(8'h00, KIND_ERR, 1'b1);
                n_cnt      = 2'd0;
                n_halted   = 1'b0;
                n_errored  = !i_last;
            end else if (r_cnt == 2'd3) begin
                pkt.cnt    = 3'd3;
                pkt.res[0] = mk_res({r_store[0][5:0], r_store[1][5:4]}, KIND_DATA, 1'b0);
                pkt.res[1] = mk_res({r_store[1][3:0], r_store[2][5:2]}, KIND_DATA, 1'b0);
                pkt.res[2] = mk_res({r_store[2][1:0], sx}, KIND_DATA, i_last);
                n_cnt      = 2'd0;
            end else begin
                n_store[r_cnt] = {2'b00, sx};
                n_cnt          = r_cnt + 2'd1;
                if (i_last) begin
                    pkt   = decode_tail(n_cnt, n_store[0][5:0], n_store[1][5:0],
                                        n_store[2][5:0]);
                    n_cnt = 2'd0;
                end
            end
        end
    end

    assign o_push = i_acc && (pkt.cnt != 3'd0);
    assign o_pkt  = pkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_ENC;
            r_cnt     <= 2'd0;
            r_halted  <= 1'b0;
            r_errored <= 1'b0;
            r_store   <= '{default: 8'h00};
        end else begin
            r_mode    <= n_mode;
            r_cnt     <= n_cnt;
            r_halted  <= n_halted;
            r_errored <= n_errored;
            r_store   <= n_store;
        end
    end

endmodule

[hw/rtl/b64c_queue.sv]
// ----------------------------------------------------------------------------
// b64c_queue
// small register queue of result packets between front and back
// ----------------------------------------------------------------------------
module b64c_queue
    import b64c_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pkt i_pkt,
    input  logic i_pop,
    output t_pkt o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_pkt          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_fill;

    assign o_full  = (r_fill == CW'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd];

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + CW'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - CW'(1);
            end
        end
    end

endmodule

[hw/rtl/b64c_back.sv]
// ----------------------------------------------------------------------------
// b64c_back
// walks each queued packet and drives one result beat per cycle while i_ready is high and a packet waits
// ----------------------------------------------------------------------------
module b64c_back
    import b64c_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_pkt i_head,
    input  logic i_empty,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    logic       r_valid, n_valid;
    t_res       r_res, n_res;
    logic [1:0] r_idx, n_idx;
    logic       load;
    logic       take;

    always_comb begin
        load    = !r_valid || i_ready;
        take    = load && !i_empty;
        n_valid = load ? !i_empty : r_valid;
        n_res   = take ? i_head.res[r_idx] : r_res;
        o_pop   = take && (r_idx == 2'(i_head.cnt - 3'd1));
        n_idx   = o_pop ? 2'd0 : (take ? r_idx + 2'd1 : r_idx);
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

[hw/rtl/base64_codec_top.sv]
// ----------------------------------------------------------------------------
// base64_codec_top
// streaming base64 encoder / decoder, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// input stream: one byte per beat on s_tdata, s_tlast closes a message
// output stream: one result per beat, m_tdata is the character or byte,
//   m_tuser the kind (data, end marker, invalid character), m_tlast closes
// i_cfg_wr_en / i_cfg_wr_data set the mode (0 encode, 1 decode) and restart
//   the message; write only while the block is idle
// latency: first result of an item shows on m_tvalid one cycle after the
//   accepting edge when the queue is empty (the front writes the queue at
//   that edge, the next edge loads the output register)
// throughput: the output register gives one result per cycle, so encode
//   takes 4 cycles per 3 bytes and decode up to 3 cycles per 4 characters;
//   the input takes one beat per cycle while the packet queue has room
// m_tready low holds the output register; the queue of P_QUEUE_DEPTH
//   packets keeps accepting until full, then s_tready drops
// reset clears mode to encode, the group state, the queue and m_tvalid
// ----------------------------------------------------------------------------
module base64_codec_top
    import b64c_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] out_kind
    output logic       m_tlast
);

    logic acc;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_pkt pkt;
    t_pkt head;
    t_res res;

    assign s_tready = !full;
    assign acc      = s_tvalid && !full;

    b64c_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_acc         (acc),
        .i_data        (s_tdata),
        .i_last        (s_tlast),
        .o_push        (push),
        .o_pkt         (pkt)
    );

    b64c_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (pkt),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    b64c_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_res   (res)
    );

    assign m_tdata = res.data;
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

[test/base64_codec_chk.sv]
// ----------------------------------------------------------------------------
// base64_codec_chk
// watches both streams of the base64 codec and predicts every result beat
// ----------------------------------------------------------------------------
// keeps its own copy of the mode and of the group state, turns each accepted
// input beat into the characters or bytes the codec should send, and compares
// every accepted output beat with the oldest of them, field by field
// ----------------------------------------------------------------------------
module base64_codec_chk
    import b64c_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_tvalid,
    input  logic       i_in_tready,
    input  logic [7:0] i_in_tdata,
    input  logic       i_in_tlast,
    input  logic       i_out_tvalid,
    input  logic       i_out_tready,
    input  logic [7:0] i_out_tdata,
    input  logic [1:0] i_out_tuser,
    input  logic       i_out_tlast,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_beats_in,
    output int         o_beats_out,
    output int         o_end_marks,
    output int         o_err_marks
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8*64-1:0] ENC_TABLE =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic       codec_mode;
    logic [7:0] grp [3];
    logic [1:0] grp_cnt;
    logic       pad_seen;
    logic       err_seen;
    t_res       codec_out_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_beats_in   = 0;
        o_beats_out  = 0;
        o_end_marks  = 0;
        o_err_marks  = 0;
    end

    function automatic logic [7:0] sextet_char(input logic [5:0] sx);
        return ENC_TABLE[8 * (63 - int'(sx)) +: 8];
    endfunction

    function automatic int char_sextet(input logic [7:0] c);
        for (int k = 0; k < 64; k++) begin
            if (sextet_char(6'(k)) == c) begin
                return k;
            end
        end
        return -1;
    endfunction

    task automatic queue_res(input logic [7:0] d, input logic [1:0] k, input logic l);
        t_res r;
        r.data = d;
        r.kind = k;
        r.last = l;
        codec_out_q = {codec_out_q, r};
    endtask

    task automatic clear_msg();
        grp_cnt  = 2'd0;
        pad_seen = 1'b0;
        err_seen = 1'b0;
    endtask

    task automatic encode_byte(input logic [7:0] d, input logic l);
        int         n;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [5:0] sx [4];
        if (grp_cnt > 2'd2) begin
            grp_cnt = 2'd0;
        end
        grp[grp_cnt] = d;
        n = int'(grp_cnt) + 1;
        if (n < 3 && !l) begin
            grp_cnt = 2'(n);
            return;
        end
        // missing bytes of a short tail count as zero
        b1 = (n > 1) ? grp[1] : 8'h00;
        b2 = (n > 2) ? grp[2] : 8'h00;
        sx[0] = grp[0][7:2];
        sx[1] = {grp[0][1:0], b1[7:4]};
        sx[2] = {b1[3:0], b2[7:6]};
        sx[3] = b2[5:0];
        for (int k = 0; k < 4; k++) begin
            queue_res((k <= n) ? sextet_char(sx[k]) : PAD_CHAR, KIND_DATA,
                      (k == 3) ? l : 1'b0);
        end
        grp_cnt = 2'd0;
    endtask

    task automatic emit_decode_tail();
        if (grp_cnt <= 2'd1) begin
            queue_res(8'h00, KIND_END, 1'b1);
        end else if (grp_cnt == 2'd2) begin
            queue_res({grp[0][5:0], grp[1][5:4]}, KIND_DATA, 1'b1);
        end else begin
            queue_res({grp[0][5:0], grp[1][5:4]}, KIND_DATA, 1'b0);
            queue_res({grp[1][3:0], grp[2][5:2]}, KIND_DATA, 1'b1);
        end
        clear_msg();
    endtask

    task automatic decode_char(input logic [7:0] c, input logic l);
        int         sx;
        logic [5:0] sx6;
        if (err_seen) begin
            if (l) begin
                clear_msg();
            end
            return;
        end
        // after a pad everything up to the last beat is dropped
        if (pad_seen || c == PAD_CHAR) begin
            pad_seen = 1'b1;
            if (l) begin
                emit_decode_tail();
            end
            return;
        end
        sx = char_sextet(c);
        if (sx < 0) begin
            queue_res(8'h00, KIND_ERR, 1'b1);
            clear_msg();
            err_seen = !l;
            return;
        end
        sx6 = 6'(sx);
        if (grp_cnt == 2'd3) begin
            queue_res({grp[0][5:0], grp[1][5:4]}, KIND_DATA, 1'b0);
            queue_res({grp[1][3:0], grp[2][5:2]}, KIND_DATA, 1'b0);
            queue_res({grp[2][1:0], sx6}, KIND_DATA, l);
            grp_cnt = 2'd0;
            return;
        end
        grp[grp_cnt] = {2'b00, sx6};
        grp_cnt++;
        if (l) begin
            emit_decode_tail();
        end
    endtask

    task automatic check_res();
        t_res got;
        t_res want;
        got.data = i_out_tdata;
        got.kind = i_out_tuser;
        got.last = i_out_tlast;
        o_beats_out++;
        if (got.kind == KIND_END) begin
            o_end_marks++;
        end
        if (got.kind == KIND_ERR) begin
            o_err_marks++;
        end
        if (codec_out_q.size() == 0) begin
            if (o_fail_count < 10) begin
                $display("%0t: unexpected beat data=%02h kind=%0d last=%0d",
                         $realtime, got.data, got.kind, got.last);
            end
            o_fail_count++;
        end else begin
            want = codec_out_q.pop_front();
            if (got.data !== want.data || got.kind !== want.kind
                    || got.last !== want.last) begin
                if (o_fail_count < 10) begin
                    $display({"%0t: beat %0d want data=%02h kind=%0d last=%0d, ",
                              "got data=%02h kind=%0d last=%0d"},
                             $realtime, o_beats_out, want.data, want.kind, want.last,
                             got.data, got.kind, got.last);
                end
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            codec_mode = MODE_ENC;
            grp[0]     = 8'h00;
            grp[1]     = 8'h00;
            grp[2]     = 8'h00;
            clear_msg();
            codec_out_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                codec_mode = i_cfg_wr_data;
                clear_msg();
            end
            if (i_in_tvalid && i_in_tready) begin
                o_beats_in++;
                if (codec_mode == MODE_ENC) begin
                    encode_byte(i_in_tdata, i_in_tlast);
                end else begin
                    decode_char(i_in_tdata, i_in_tlast);
                end
            end
            if (i_out_tvalid && i_out_tready) begin
                check_res();
            end
        end
        o_pending = codec_out_q.size();
    end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// stream test of the base64 codec in both encode and decode mode
// ----------------------------------------------------------------------------
// drives directed messages (full and short groups, padding, bad characters,
// pad-only and one-character tails, restart by mode write) and then random
// messages in both modes, with random gaps on both streams and one long
// output hold-off; base64_codec_chk predicts and compares every beat
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b64c_pkg::*;

    localparam logic     MODE_DEC        = ~MODE_ENC;
    localparam int       SETTLE_CYCLES   = 8;
    localparam int       HOLD_OFF_CYCLES = 300;
    localparam int       TIMEOUT_NS      = 1_000_000;
    localparam logic [8*64-1:0] B64_CHARS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef logic [7:0] t_byte_q [$];

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic       i_cfg_wr_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    int fail_count;
    int n_pending;
    int beats_in;
    int beats_out;
    int end_marks;
    int err_marks;
    int cfg_writes  = 0;
    int burst_left  = 0;
    bit hold_off_req = 1'b0;
    bit hold_done    = 1'b0;

    always #1 i_clk = ~i_clk;

    base64_codec_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

    base64_codec_chk u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_tvalid   (s_tvalid),
        .i_in_tready   (s_tready),
        .i_in_tdata    (s_tdata),
        .i_in_tlast    (s_tlast),
        .i_out_tvalid  (m_tvalid),
        .i_out_tready  (m_tready),
        .i_out_tdata   (m_tdata),
        .i_out_tuser   (m_tuser),
        .i_out_tlast   (m_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (n_pending),
        .o_beats_in    (beats_in),
        .o_beats_out   (beats_out),
        .o_end_marks   (end_marks),
        .o_err_marks   (err_marks)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] b64_char(input int k);
        return B64_CHARS[8 * (63 - k) +: 8];
    endfunction

    task automatic send_beat(input logic [7:0] d, input logic l, input bit no_gaps);
        int n_gap;
        n_gap = no_gaps ? 0 : pick_gap();
        if (n_gap > 0) begin
            s_tvalid = 1'b0;
            repeat (n_gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        s_tlast  = l;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_msg(input t_byte_q msg, input bit close);
        bit no_gaps;
        no_gaps = (burst_left > 0) || ($urandom_range(0, 4) == 0);
        foreach (msg[i]) begin
            send_beat(msg[i], close && (i == msg.size() - 1), no_gaps);
        end
        burst_left = (burst_left > msg.size()) ? burst_left - msg.size() : 0;
    endtask

    task automatic send_text(input string txt, input bit close);
        t_byte_q msg;
        msg = {};
        for (int i = 0; i < txt.len(); i++) begin
            msg = {msg, txt[i]};
        end
        send_msg(msg, close);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (n_pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        wait_drained();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = m;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        cfg_writes++;
    endtask

    task automatic encode_phase(input int n_items, input bit with_hold);
        t_byte_q msg;
        int      left;
        int      len;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                              : $urandom_range(1, 7);
            msg = {};
            repeat (len) msg = {msg, 8'($urandom_range(0, 255))};
            // stop the output for a while and keep the input busy
            if (with_hold && !hold_done && left < n_items - 15) begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
                burst_left   = 40;
            end
            send_msg(msg, 1'b1);
            left -= len;
        end
    endtask

    task automatic decode_phase(input int n_items);
        t_byte_q msg;
        int      left;
        int      r;
        left = n_items;
        while (left > 0) begin
            r   = $urandom_range(0, 19);
            msg = {};
            repeat ($urandom_range(1, 13)) msg = {msg, b64_char($urandom_range(0, 63))};
            if (r < 14) begin
                if ($urandom_range(0, 3) != 0) begin
                    while (msg.size() % 4 != 0) msg = {msg, PAD_CHAR};
                end
            end else if (r < 17) begin
                msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
            end else if (r < 19) begin
                // junk after the pad
                msg = {msg, PAD_CHAR};
                repeat ($urandom_range(1, 3)) msg = {msg, 8'($urandom_range(0, 255))};
            end else begin
                msg = {};
                repeat ($urandom_range(1, 6)) msg = {msg, 8'($urandom_range(0, 255))};
            end
            send_msg(msg, 1'b1);
            left -= msg.size();
        end
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int n_idle;
        m_tready = 1'b0;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                n_idle       = HOLD_OFF_CYCLES;
            end else begin
                n_idle = pick_gap();
            end
            if (n_idle > 0) begin
                m_tready = 1'b0;
                repeat (n_idle) @(negedge i_clk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    end

    initial begin
        t_byte_q msg;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tlast       = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // encode straight out of reset
        msg = {8'h00, 8'hFF, 8'h80};
        send_msg(msg, 1'b1);
        msg = {8'hFF};
        send_msg(msg, 1'b1);
        msg = {8'h00, 8'hFF};
        send_msg(msg, 1'b1);
        msg = {8'hA5};
        send_msg(msg, 1'b0);

        // mode write drops the open group
        write_mode(MODE_DEC);
        send_text("QQ==", 1'b1);
        send_text("QUI=", 1'b1);
        send_text("A*B", 1'b1);
        send_text("*", 1'b1);
        send_text("=", 1'b1);
        send_text("A", 1'b1);
        send_text("QU", 1'b0);

        write_mode(MODE_ENC);
        encode_phase(90, 1'b1);
        write_mode(MODE_DEC);
        decode_phase(90);
        write_mode(MODE_DEC);
        decode_phase(50);
        write_mode(MODE_ENC);
        encode_phase(50, 1'b0);
        write_mode(MODE_DEC);
        decode_phase(40);

        wait_drained();
        $display("run covered %0d input beats over %0d mode writes in both modes",
                 beats_in, cfg_writes);
        $display("checked %0d output beats, %0d end markers and %0d bad-character errors",
                 beats_out, end_marks, err_marks);
        if (fail_count == 0) begin
            $display("base64_codec_top test passed");
        end else begin
            $display("base64_codec_top test failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d beats still expected", n_pending);
        $display("base64_codec_top test failed");
        $finish;
    end

endmodule
